### rtl/sta_lta_event_detector_assert.svh
// Assertion macros for the STA/LTA event detector.
// SLD_ASSERT takes an explicit clock and active-low reset;
// SLD_ASSERT_DEF uses clk_i and rst_ni of the enclosing module.
`ifndef STA_LTA_EVENT_DETECTOR_ASSERT_SVH
`define STA_LTA_EVENT_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sta_lta_event_detector: assertion failed");
`define SLD_ASSERT_DEF(lbl, prop) `SLD_ASSERT(lbl, clk_i, rst_ni, prop)
`else
`define SLD_ASSERT(lbl, clk, rstn, prop)
`define SLD_ASSERT_DEF(lbl, prop)
`endif

`endif

### rtl/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

  // Threshold register, unsigned Q8.8
  localparam int THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd256;

  // Event index and sample counter
  localparam int IDX_W = 32;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // Shared multiplier operand A width; long sums are split into chunks of this size
  localparam int MUL_A_W = 32;

endpackage

### rtl/sld_stream_if.sv
`timescale 1ns / 1ps

interface sld_sample_if #(
  parameter int SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sld_event_if import sld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] event_index;

  modport source (output valid, output event_index, input ready);
  modport sink   (input valid, input event_index, output ready);
endinterface

### rtl/sld_cell.sv
`timescale 1ns / 1ps

// One stage of the square delay line: load from the left neighbor on shift.
module sld_cell #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] val_q;
  logic [WIDTH-1:0] val_d;

  assign val_d = shift_i ? d_i : val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

### rtl/sld_mul.sv
`timescale 1ns / 1ps

// Shared unsigned multiplier with a registered product.
module sld_mul #(
  parameter int A_W = 32,
  parameter int B_W = 18
) (
  input  logic               clk_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] prod_q;
  logic [A_W+B_W-1:0] prod_d;

  assign prod_d = (A_W + B_W)'(a_i) * (A_W + B_W)'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign p_o = prod_q;

endmodule

### rtl/sta_lta_event_detector.sv
`timescale 1ns / 1ps

// STA/LTA seismic event detector.
// Input channel sample_i (valid/ready) carries one signed sample per transaction.
// Output channel event_o (valid/ready) carries the zero-based index of each sample
// whose short-window mean power exceeds ratio_threshold (unsigned Q8.8) times the
// long-window mean power; samples that do not trigger produce no transaction.
// Squares of the last LONG_LEN samples move through a row of delay cells; running
// short and long sums are updated from fixed taps of that row.
// Timing: a sequencer steps each sample through one shared multiplier (square,
// then two 32-bit chunks of long_sum * SHORT_LEN * threshold), an accumulate and
// a final compare; an event is registered on event_o when the compare finishes.
// sample_i.ready is high only while the sequencer is idle.
// Configuration: write ratio_threshold with cfg_we_i / cfg_wdata_i while idle.
// Reset (rst_ni low, asynchronous) clears delay cells, sums, counter and output
// valid, and sets the threshold to 1.0 (256).
// Stall: the result sits in an output register; if it is still held when the next
// compare finishes, the sequencer waits in its compare step until event_o drains.
// The sample counter saturates at all ones; later events report that index.
module sta_lta_event_detector import sld_pkg::*; #(
  parameter int SHORT_LEN   = 2,
  parameter int LONG_LEN    = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  sld_sample_if.sink       sample_i,
  sld_event_if.source      event_o
);

`include "sta_lta_event_detector_assert.svh"

  // Widths
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int LS_W   = SQ_W + $clog2(LONG_LEN);
  localparam int SS_W   = (SHORT_LEN > 1) ? SQ_W + $clog2(SHORT_LEN) : SQ_W;
  localparam int KS_W   = THR_W + $clog2(SHORT_LEN + 1);
  localparam int MB_W   = (KS_W > SAMPLE_BITS) ? KS_W : SAMPLE_BITS;
  localparam int P_W    = MUL_A_W + MB_W;
  localparam int PAD_W  = 2 * MUL_A_W;
  localparam int LHS_W  = SS_W + 8 + $clog2(LONG_LEN + 1);
  localparam int RHS_W  = PAD_W + KS_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_HI   = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [THR_W-1:0]       thr_q, thr_d;
  logic [SAMPLE_BITS-1:0] mag_q, mag_d;
  logic [LS_W-1:0]        long_q, long_d;
  logic [SS_W-1:0]        short_q, short_d;
  logic [IDX_W-1:0]       count_q, count_d;
  logic [CMP_W-1:0]       lhs_q, lhs_d;
  logic [CMP_W-1:0]       acc_q, acc_d;
  logic [CMP_W-1:0]       rhs_q, rhs_d;
  logic                   ev_valid_q, ev_valid_d;
  logic [IDX_W-1:0]       ev_idx_q, ev_idx_d;

  logic [SAMPLE_BITS-1:0] sample_bits;
  logic                   in_fire;
  logic [KS_W-1:0]        ksh;
  logic [PAD_W-1:0]       long_pad;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [P_W-1:0]         mul_p;
  logic [SQ_W-1:0]        sq;
  logic                   shift;
  logic                   hit;
  logic                   can_finish;
  logic [SQ_W-1:0]        tap [LONG_LEN];

  assign sample_bits = sample_i.sample[SAMPLE_BITS-1:0];
  assign in_fire     = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == S_IDLE);

  // Magnitude; the most negative sample wraps to 2^(SAMPLE_BITS-1), as unsigned
  assign mag_d = sample_bits[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample_bits) : sample_bits;

  assign ksh      = KS_W'(thr_q) * KS_W'(SHORT_LEN);
  assign long_pad = PAD_W'(long_q);
  assign sq       = mul_p[SQ_W-1:0];
  assign shift    = (state_q == S_UPD);

  // Share the multiplier: square first, then long_sum chunks times SHORT_LEN * threshold
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MB_W'(mag_q);
      end
      S_LO: begin
        mul_a = long_pad[MUL_A_W-1:0];
        mul_b = MB_W'(ksh);
      end
      S_HI: begin
        mul_a = long_pad[PAD_W-1:MUL_A_W];
        mul_b = MB_W'(ksh);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sld_mul #(
    .A_W (MUL_A_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Delay line of squares: cell 0 holds the newest, cell LONG_LEN-1 the oldest
  for (genvar k = 0; k < LONG_LEN; k++) begin : g_cell
    logic [SQ_W-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = sq;
    end else begin : g_link
      assign cell_d = tap[k-1];
    end
    sld_cell #(
      .WIDTH (SQ_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (cell_d),
      .q_o     (tap[k])
    );
  end

  // Trigger: warmed up, nonzero long power and LONG*256*short > SHORT*thr*long
  assign hit = (count_q >= IDX_W'(LONG_LEN - 1)) && (long_q != '0) && (lhs_q > rhs_q);
  assign can_finish = !ev_valid_q || event_o.ready;

  always_comb begin
    state_d    = state_q;
    thr_d      = cfg_we_i ? cfg_wdata_i : thr_q;
    long_d     = long_q;
    short_d    = short_q;
    count_d    = count_q;
    lhs_d      = lhs_q;
    acc_d      = acc_q;
    rhs_d      = rhs_q;
    ev_idx_d   = ev_idx_q;
    // Drop the held event once the receiver takes it
    ev_valid_d = ev_valid_q && !event_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        // The oldest square leaves the long window, the one SHORT_LEN back the short
        long_d  = long_q + LS_W'(sq) - LS_W'(tap[LONG_LEN-1]);
        short_d = short_q + SS_W'(sq) - SS_W'(tap[SHORT_LEN-1]);
        state_d = S_LO;
      end
      S_LO: begin
        lhs_d   = CMP_W'(short_q) * CMP_W'(LONG_LEN * 256);
        state_d = S_HI;
      end
      S_HI: begin
        acc_d   = CMP_W'(mul_p);
        state_d = S_ACC;
      end
      S_ACC: begin
        rhs_d   = (CMP_W'(mul_p) << MUL_A_W) + acc_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        // Hold here while an earlier event still waits on event_o
        if (can_finish) begin
          if (hit) begin
            ev_valid_d = 1'b1;
            ev_idx_d   = count_q;
          end
          if (count_q != IDX_MAX) begin
            count_d = count_q + IDX_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      thr_q      <= THR_RESET;
      long_q     <= '0;
      short_q    <= '0;
      count_q    <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      thr_q      <= thr_d;
      long_q     <= long_d;
      short_q    <= short_d;
      count_q    <= count_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q <= mag_d;
    end
    lhs_q    <= lhs_d;
    acc_q    <= acc_d;
    rhs_q    <= rhs_d;
    ev_idx_q <= ev_idx_d;
  end

  assign event_o.valid       = ev_valid_q;
  assign event_o.event_index = ev_idx_q;

  // An event is only raised by the compare step
  `SLD_ASSERT_DEF(a_event_from_cmp, $rose(ev_valid_q) |-> ($past(state_q) == S_CMP))
  // The short window is part of the long window
  `SLD_ASSERT_DEF(a_short_le_long, LS_W'(short_q) <= long_q)
  // The sample counter advances only when a sample completes
  `SLD_ASSERT_DEF(a_count_at_cmp, (state_q != S_CMP) |=> $stable(count_q))

endmodule

### verif/sta_lta_event_detector_test.sv
`timescale 1ns / 1ps

module sta_lta_event_detector_test;
  import sld_pkg::*;

  localparam int SHORT_LEN   = 2;
  localparam int LONG_LEN    = 5;
  localparam int SAMPLE_BITS = 16;

  // Enough quiet cycles for a sample in flight through the sequencer to settle.
  localparam int SETTLE_CYCLES = 16;
  // Far above the cycles that even the slowest correct run needs.
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  sld_sample_if #(.SampleBits(SAMPLE_BITS)) sample_ch ();
  sld_event_if event_ch ();

  sta_lta_event_detector #(
    .SHORT_LEN  (SHORT_LEN),
    .LONG_LEN   (LONG_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_ch),
    .event_o    (event_ch)
  );

  // Clock: 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Power-window tracker state: a private copy of the detector's history,
  // running sums, sample count and threshold.
  logic [2*SAMPLE_BITS-2:0] square_hist [LONG_LEN];
  int                       hist_pos;
  logic [63:0]              sta_power;
  logic [63:0]              lta_power;
  logic [IDX_W-1:0]         samples_seen;
  logic [THR_W-1:0]         ratio_thr;

  // Event indexes the detector still owes us, oldest first.
  logic [IDX_W-1:0] expected_events [$];

  int unsigned fail_count;
  int unsigned cycle_count;

  // Idle/stall knobs: off for the final stretch of the run.
  bit src_gaps_on;
  bit snk_stalls_on;
  int stall_left;

  // Square the sample, slide both windows and decide whether the
  // short/long power ratio beats the threshold. The comparison is done
  // without division: LONG*sta*256 > SHORT*thr*lta.
  task automatic track_power_windows(input logic signed [SAMPLE_BITS-1:0] value);
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-2:0] sq;
    logic [63:0]              lhs;
    logic [63:0]              rhs;
    int                       short_tail;
    mag        = value[SAMPLE_BITS-1] ? (~value + 1'b1) : value;
    sq         = (2*SAMPLE_BITS-1)'(64'(mag) * 64'(mag));
    short_tail = (hist_pos + LONG_LEN - SHORT_LEN) % LONG_LEN;
    // Oldest square leaves the long window, the one SHORT_LEN back leaves
    // the short window.
    lta_power  = lta_power + 64'(sq) - 64'(square_hist[hist_pos]);
    sta_power  = sta_power + 64'(sq) - 64'(square_hist[short_tail]);
    square_hist[hist_pos] = sq;
    hist_pos   = (hist_pos + 1) % LONG_LEN;
    // Warm-up and zero long power never trigger.
    if (samples_seen >= IDX_W'(LONG_LEN - 1) && lta_power != 64'd0) begin
      lhs = sta_power * 64'(LONG_LEN * 256);
      rhs = lta_power * (64'(SHORT_LEN) * 64'(ratio_thr));
      if (lhs > rhs) expected_events.push_back(samples_seen);
    end
    // Saturate rather than wrap.
    if (samples_seen != IDX_MAX) samples_seen = samples_seen + 1'b1;
  endtask

  // Drive one sample transaction and update the tracker once it is taken.
  // Valid is dropped after each transaction; the next one is raised at a
  // later edge, which costs nothing since ready falls while the sequencer runs.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    int gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 7);
    repeat (gap) @(posedge clk_i);
    @(posedge clk_i);
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
    sample_ch.valid <= 1'b0;
    track_power_windows(value);
  endtask

  // Hold until every owed event has arrived, then let any sample that
  // triggers nothing finish inside the sequencer.
  task automatic wait_detector_idle();
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ratio_threshold(input logic [THR_W-1:0] value);
    wait_detector_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ratio_thr = value;
  endtask

  // Random trace shaped like seismic data: mostly quiet background with
  // sudden onsets, plus dead (all-zero) stretches and scattered full-range noise.
  task automatic send_seismic_trace(input int count);
    logic signed [SAMPLE_BITS-1:0] value;
    int sent;
    int kind;
    int run;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        run = $urandom_range(3, 12);
        repeat (run) begin
          value = SAMPLE_BITS'($urandom_range(0, 63));
          value = value - 16'sd32;
          send_sample(value);
          sent++;
        end
        run = $urandom_range(1, 5);
        repeat (run) begin
          value = SAMPLE_BITS'($urandom());
          send_sample(value);
          sent++;
        end
      end else if (kind == 6) begin
        run = $urandom_range(3, 8);
        repeat (run) begin
          send_sample('0);
          sent++;
        end
      end else begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          value = SAMPLE_BITS'($urandom());
          send_sample(value);
          sent++;
        end
      end
    end
  endtask

  // Warm-up: a loud first sample must not trigger before LONG_LEN-1 samples.
  // Then let the window empty out so long power returns to zero.
  task automatic test_warmup_and_dead_window();
    send_sample(16'sd1000);
    repeat (6) send_sample('0);
  endtask

  // Sample extremes, including the most negative value whose square is the
  // widest the history has to hold; trailing zeros empty the window again.
  task automatic test_sample_extremes();
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    repeat (5) send_sample('0);
  endtask

  // Walk the threshold through its range: default 1.0, zero (any short power
  // triggers), all ones (nothing can trigger) and values near the 2.5 ceiling
  // that LONG_LEN/SHORT_LEN allows.
  task automatic test_threshold_sweep();
    send_seismic_trace(120);
    write_ratio_threshold('0);
    send_seismic_trace(60);
    write_ratio_threshold('1);
    send_seismic_trace(40);
    write_ratio_threshold(THR_W'(639));
    send_seismic_trace(40);
    write_ratio_threshold(THR_W'($urandom_range(300, 600)));
    send_seismic_trace(140);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    write_ratio_threshold(THR_W'(384));
    src_gaps_on   = 1'b0;
    snk_stalls_on = 1'b0;
    send_seismic_trace(150);
  endtask

  // Event sink: random stall bursts while enabled.
  always @(posedge clk_i) begin
    if (stall_left == 0 && snk_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    if (stall_left > 0) begin
      event_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      event_ch.ready <= 1'b1;
    end
  end

  // Compare every event transaction with the oldest owed index.
  always @(posedge clk_i) begin : event_check
    logic [IDX_W-1:0] want;
    if (rst_ni && event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected event: index %0d", event_ch.event_index);
        end
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_ch.event_index !== want) begin
          if (fail_count < 10) begin
            $display("event_index mismatch: expected %0d, got %0d", want,
                     event_ch.event_index);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sta_lta_event_detector_test: errors");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = THR_RESET;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    event_ch.ready   = 1'b0;
    src_gaps_on      = 1'b1;
    snk_stalls_on    = 1'b1;
    stall_left       = 0;
    fail_count       = 0;
    cycle_count      = 0;
    // Tracker starts from the detector's reset state.
    foreach (square_hist[i]) square_hist[i] = '0;
    hist_pos     = 0;
    sta_power    = '0;
    lta_power    = '0;
    samples_seen = '0;
    ratio_thr    = THR_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warmup_and_dead_window();
    test_sample_extremes();
    test_threshold_sweep();
    test_steady_stream();

    // Drain, then give the sequencer time to show any stray event.
    wait_detector_idle();
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("sta_lta_event_detector_test: clean");
    end else begin
      $display("sta_lta_event_detector_test: errors");
    end
    $finish;
  end

endmodule

### sta_lta_event_detector.f
+incdir+rtl
rtl/sld_pkg.sv
rtl/sld_stream_if.sv
rtl/sld_cell.sv
rtl/sld_mul.sv
rtl/sta_lta_event_detector.sv
verif/sta_lta_event_detector_test.sv
